// ===== hdl/semaphore_blocked_queue_table_top_macros.svh =====
// ----------------------------------------------------------------------------
// semaphore blocked queue table assertion macros
// shared assertion forms for the table's concurrent checks
// ----------------------------------------------------------------------------
`ifndef SEMAPHORE_BLOCKED_QUEUE_TABLE_TOP_MACROS_SVH
`define SEMAPHORE_BLOCKED_QUEUE_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define SBQT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SBQT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sbqt_pkg.sv =====
// ----------------------------------------------------------------------------
// sbqt_pkg
// shared constants, codes and types of the semaphore blocked queue table
// ----------------------------------------------------------------------------
package sbqt_pkg;

  localparam int NUM_ENTRIES_DEF = 32;
  localparam int NUM_PROCS       = 32;
  localparam int PROC_W          = 5;
  localparam int KEY_W           = 32;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_OUT    = 2'd2;
  localparam logic [1:0] CMD_HEAD   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FREE  = 2'd1;
  localparam logic [1:0] ST_NOT_FND  = 2'd2;
  localparam logic [1:0] ST_BLOCKED  = 2'd3;

  typedef struct packed {
    logic [1:0]        status;
    logic [PROC_W-1:0] proc_id;
    logic              proc_vld;
  } res_t;

endpackage

// ===== hdl/sbqt_ram.sv =====
// ----------------------------------------------------------------------------
// sbqt_ram
// generic one-write one-read memory with registered read data
// ----------------------------------------------------------------------------
module sbqt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/sbqt_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbqt_ctrl
// command sequencer: descriptor scan, queue walk and read-modify-write
// ----------------------------------------------------------------------------
module sbqt_ctrl #(
  parameter int NUM_ENTRIES = sbqt_pkg::NUM_ENTRIES_DEF,
  parameter int IDX_W       = $clog2(NUM_ENTRIES),
  parameter int DESC_W      = sbqt_pkg::KEY_W + 2 * sbqt_pkg::PROC_W,
  parameter int PMEM_W      = IDX_W + sbqt_pkg::PROC_W
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_cmd,
  input  logic [sbqt_pkg::KEY_W-1:0]  in_key,
  input  logic [sbqt_pkg::PROC_W-1:0] in_pid,
  output logic                        d_we,
  output logic [IDX_W-1:0]            d_waddr,
  output logic [DESC_W-1:0]           d_wdata,
  output logic [IDX_W-1:0]            d_raddr,
  input  logic [DESC_W-1:0]           d_rdata,
  output logic                        p_we,
  output logic [sbqt_pkg::PROC_W-1:0] p_waddr,
  output logic [PMEM_W-1:0]           p_wdata,
  output logic [sbqt_pkg::PROC_W-1:0] p_raddr,
  input  logic [PMEM_W-1:0]           p_rdata,
  output logic                        res_valid,
  input  logic                        res_ready,
  output sbqt_pkg::res_t              res
);

  localparam int PW = sbqt_pkg::PROC_W;
  localparam int KW = sbqt_pkg::KEY_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_CMP = 4'd3;
  localparam logic [3:0] S_AFTER    = 4'd4;
  localparam logic [3:0] S_INS_DESC = 4'd5;
  localparam logic [3:0] S_INS_PROC = 4'd6;
  localparam logic [3:0] S_RM_DATA  = 4'd7;
  localparam logic [3:0] S_OUT_PD   = 4'd8;
  localparam logic [3:0] S_OUT_DD   = 4'd9;
  localparam logic [3:0] S_WALK     = 4'd10;
  localparam logic [3:0] S_WALK_NX  = 4'd11;
  localparam logic [3:0] S_UNLINK   = 4'd12;
  localparam logic [3:0] S_UNL_DATA = 4'd13;
  localparam logic [3:0] S_UNL_TAIL = 4'd14;
  localparam logic [3:0] S_DONE     = 4'd15;

  logic [3:0]             state_r, state_nxt;
  logic [NUM_ENTRIES-1:0] active_r, active_nxt;
  logic [sbqt_pkg::NUM_PROCS-1:0] blocked_r, blocked_nxt;

  logic [1:0]       cmd_r, cmd_nxt;
  logic [KW-1:0]    key_r, key_nxt;
  logic [PW-1:0]    pid_r, pid_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] d_r, d_nxt;
  logic             free_vld_r, free_vld_nxt;
  logic [IDX_W-1:0] free_r, free_nxt;
  logic [KW-1:0]    dkey_r, dkey_nxt;
  logic [PW-1:0]    head_r, head_nxt;
  logic [PW-1:0]    tail_r, tail_nxt;
  logic [PW-1:0]    cur_r, cur_nxt;
  logic [PW-1:0]    prev_r, prev_nxt;
  logic             first_r, first_nxt;
  logic [PW-1:0]    steps_r, steps_nxt;
  sbqt_pkg::res_t   res_r, res_nxt;

  logic [KW-1:0]    rd_key;
  logic [PW-1:0]    rd_head;
  logic [PW-1:0]    rd_tail;
  logic [IDX_W-1:0] rd_pidx;
  logic [PW-1:0]    rd_pnext;

  assign rd_key   = d_rdata[DESC_W-1 -: KW];
  assign rd_head  = d_rdata[2*PW-1 -: PW];
  assign rd_tail  = d_rdata[PW-1:0];
  assign rd_pidx  = p_rdata[PMEM_W-1 -: IDX_W];
  assign rd_pnext = p_rdata[PW-1:0];

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_comb begin
    state_nxt    = state_r;
    active_nxt   = active_r;
    blocked_nxt  = blocked_r;
    cmd_nxt      = cmd_r;
    key_nxt      = key_r;
    pid_nxt      = pid_r;
    cnt_nxt      = cnt_r;
    found_nxt    = found_r;
    d_nxt        = d_r;
    free_vld_nxt = free_vld_r;
    free_nxt     = free_r;
    dkey_nxt     = dkey_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    cur_nxt      = cur_r;
    prev_nxt     = prev_r;
    first_nxt    = first_r;
    steps_nxt    = steps_r;
    res_nxt      = res_r;
    d_we         = 1'b0;
    d_waddr      = d_r;
    d_wdata      = {dkey_r, head_r, tail_r};
    d_raddr      = cnt_r;
    p_we         = 1'b0;
    p_waddr      = pid_r;
    p_wdata      = {d_r, pid_r};
    p_raddr      = pid_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          key_nxt   = in_key;
          pid_nxt   = in_pid;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cnt_nxt      = '0;
        found_nxt    = 1'b0;
        free_vld_nxt = 1'b0;
        if (cmd_r == sbqt_pkg::CMD_OUT) begin
          if (blocked_r[pid_r]) begin
            p_raddr   = pid_r;
            state_nxt = S_OUT_PD;
          end else begin
            res_nxt   = '{sbqt_pkg::ST_NOT_FND, '0, 1'b0};
            state_nxt = S_DONE;
          end
        end else if (cmd_r == sbqt_pkg::CMD_INSERT && blocked_r[pid_r]) begin
          res_nxt   = '{sbqt_pkg::ST_BLOCKED, '0, 1'b0};
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        d_raddr   = cnt_r;
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (active_r[cnt_r] && rd_key == key_r) begin
          found_nxt = 1'b1;
          d_nxt     = cnt_r;
          dkey_nxt  = rd_key;
          head_nxt  = rd_head;
          tail_nxt  = rd_tail;
          state_nxt = S_AFTER;
        end else begin
          if (!active_r[cnt_r] && !free_vld_r) begin
            free_vld_nxt = 1'b1;
            free_nxt     = cnt_r;
          end
          if (cnt_r == IDX_W'(NUM_ENTRIES - 1)) begin
            state_nxt = S_AFTER;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_AFTER: begin
        if (cmd_r == sbqt_pkg::CMD_INSERT) begin
          if (found_r) begin
            p_we      = 1'b1;
            p_waddr   = tail_r;
            p_wdata   = {d_r, pid_r};
            state_nxt = S_INS_DESC;
          end else if (free_vld_r) begin
            active_nxt[free_r] = 1'b1;
            d_we      = 1'b1;
            d_waddr   = free_r;
            d_wdata   = {key_r, pid_r, pid_r};
            d_nxt     = free_r;
            state_nxt = S_INS_PROC;
          end else begin
            res_nxt   = '{sbqt_pkg::ST_NO_FREE, '0, 1'b0};
            state_nxt = S_DONE;
          end
        end else if (!found_r) begin
          res_nxt   = '{sbqt_pkg::ST_NOT_FND, '0, 1'b0};
          state_nxt = S_DONE;
        end else if (cmd_r == sbqt_pkg::CMD_HEAD) begin
          res_nxt   = '{sbqt_pkg::ST_OK, head_r, 1'b1};
          state_nxt = S_DONE;
        end else begin
          blocked_nxt[head_r] = 1'b0;
          res_nxt = '{sbqt_pkg::ST_OK, head_r, 1'b1};
          if (head_r == tail_r) begin
            active_nxt[d_r] = 1'b0;
            state_nxt = S_DONE;
          end else begin
            p_raddr   = head_r;
            state_nxt = S_RM_DATA;
          end
        end
      end
      S_INS_DESC: begin
        d_we      = 1'b1;
        d_waddr   = d_r;
        d_wdata   = {dkey_r, head_r, pid_r};
        state_nxt = S_INS_PROC;
      end
      S_INS_PROC: begin
        p_we      = 1'b1;
        p_waddr   = pid_r;
        p_wdata   = {d_r, PW'(0)};
        blocked_nxt[pid_r] = 1'b1;
        res_nxt   = '{sbqt_pkg::ST_OK, '0, 1'b0};
        state_nxt = S_DONE;
      end
      S_RM_DATA: begin
        d_we      = 1'b1;
        d_waddr   = d_r;
        d_wdata   = {dkey_r, rd_pnext, tail_r};
        state_nxt = S_DONE;
      end
      S_OUT_PD: begin
        d_nxt   = rd_pidx;
        d_raddr = rd_pidx;
        if (active_r[rd_pidx]) begin
          state_nxt = S_OUT_DD;
        end else begin
          res_nxt   = '{sbqt_pkg::ST_NOT_FND, '0, 1'b0};
          state_nxt = S_DONE;
        end
      end
      S_OUT_DD: begin
        dkey_nxt  = rd_key;
        head_nxt  = rd_head;
        tail_nxt  = rd_tail;
        cur_nxt   = rd_head;
        first_nxt = 1'b1;
        steps_nxt = '0;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (cur_r == pid_r) begin
          state_nxt = S_UNLINK;
        end else if (cur_r == tail_r || steps_r == PW'(sbqt_pkg::NUM_PROCS - 1)) begin
          res_nxt   = '{sbqt_pkg::ST_NOT_FND, '0, 1'b0};
          state_nxt = S_DONE;
        end else begin
          prev_nxt  = cur_r;
          first_nxt = 1'b0;
          p_raddr   = cur_r;
          state_nxt = S_WALK_NX;
        end
      end
      S_WALK_NX: begin
        cur_nxt   = rd_pnext;
        steps_nxt = steps_r + 1'b1;
        state_nxt = S_WALK;
      end
      S_UNLINK: begin
        blocked_nxt[pid_r] = 1'b0;
        res_nxt = '{sbqt_pkg::ST_OK, pid_r, 1'b1};
        if (first_r && pid_r == tail_r) begin
          active_nxt[d_r] = 1'b0;
          state_nxt = S_DONE;
        end else begin
          p_raddr   = pid_r;
          state_nxt = S_UNL_DATA;
        end
      end
      S_UNL_DATA: begin
        if (first_r) begin
          d_we      = 1'b1;
          d_waddr   = d_r;
          d_wdata   = {dkey_r, rd_pnext, tail_r};
          state_nxt = S_DONE;
        end else begin
          p_we    = 1'b1;
          p_waddr = prev_r;
          p_wdata = {d_r, rd_pnext};
          state_nxt = (pid_r == tail_r) ? S_UNL_TAIL : S_DONE;
        end
      end
      S_UNL_TAIL: begin
        d_we      = 1'b1;
        d_waddr   = d_r;
        d_wdata   = {dkey_r, head_r, prev_r};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      active_r  <= '0;
      blocked_r <= '0;
    end else begin
      state_r   <= state_nxt;
      active_r  <= active_nxt;
      blocked_r <= blocked_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    pid_r      <= pid_nxt;
    cnt_r      <= cnt_nxt;
    found_r    <= found_nxt;
    d_r        <= d_nxt;
    free_vld_r <= free_vld_nxt;
    free_r     <= free_nxt;
    dkey_r     <= dkey_nxt;
    head_r     <= head_nxt;
    tail_r     <= tail_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    first_r    <= first_nxt;
    steps_r    <= steps_nxt;
    res_r      <= res_nxt;
  end

endmodule

// ===== hdl/semaphore_blocked_queue_table_top.sv =====
// ----------------------------------------------------------------------------
// semaphore_blocked_queue_table_top
// table of semaphore descriptors, each holding a fifo of blocked processes
// ----------------------------------------------------------------------------
// One request is handled at a time and gives exactly one result. Descriptors
// (key, head, tail) sit in one memory and per-process links (descriptor index,
// next) in another; both have registered read data. Insert, remove head
// and peek scan the descriptor memory entry by entry, reading and then
// comparing each one, and stop at the first match. Remove-given
// skips the scan and walks the queue through the process memory, following
// the next links from the head until it reaches the given process.
// An insert of an already blocked process or a remove-given of a process
// that is not blocked is answered straight from dispatch. A new request is taken as
// soon as the previous result has moved into the output register.
// ----------------------------------------------------------------------------
`include "semaphore_blocked_queue_table_top_macros.svh"

module semaphore_blocked_queue_table_top #(
  parameter int NUM_ENTRIES = sbqt_pkg::NUM_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_cmd,
  input  logic [sbqt_pkg::KEY_W-1:0]  in_sem_key,
  input  logic [sbqt_pkg::PROC_W-1:0] in_proc_id,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [sbqt_pkg::PROC_W-1:0] out_result_proc,
  output logic                        out_result_valid
);

  localparam int IDX_W  = $clog2(NUM_ENTRIES);
  localparam int DESC_W = sbqt_pkg::KEY_W + 2 * sbqt_pkg::PROC_W;
  localparam int PMEM_W = IDX_W + sbqt_pkg::PROC_W;

  logic                        d_we;
  logic [IDX_W-1:0]            d_waddr;
  logic [DESC_W-1:0]           d_wdata;
  logic [IDX_W-1:0]            d_raddr;
  logic [DESC_W-1:0]           d_rdata;
  logic                        p_we;
  logic [sbqt_pkg::PROC_W-1:0] p_waddr;
  logic [PMEM_W-1:0]           p_wdata;
  logic [sbqt_pkg::PROC_W-1:0] p_raddr;
  logic [PMEM_W-1:0]           p_rdata;
  logic                        res_valid;
  logic                        res_ready;
  sbqt_pkg::res_t              res;

  logic                        out_valid_r;
  sbqt_pkg::res_t              out_res_r;

  sbqt_ram #(
    .WIDTH (DESC_W),
    .DEPTH (NUM_ENTRIES)
  ) u_desc_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  sbqt_ram #(
    .WIDTH (PMEM_W),
    .DEPTH (sbqt_pkg::NUM_PROCS)
  ) u_proc_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  sbqt_ctrl #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .in_key    (in_sem_key),
    .in_pid    (in_proc_id),
    .d_we      (d_we),
    .d_waddr   (d_waddr),
    .d_wdata   (d_wdata),
    .d_raddr   (d_raddr),
    .d_rdata   (d_rdata),
    .p_we      (p_we),
    .p_waddr   (p_waddr),
    .p_wdata   (p_wdata),
    .p_raddr   (p_raddr),
    .p_rdata   (p_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_res_r.status;
  assign out_result_proc  = out_res_r.proc_id;
  assign out_result_valid = out_res_r.proc_vld;

  `SBQT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "request accepted while busy")
  `SBQT_ASSERT_SAME(a_fail_no_proc, out_valid && out_status != sbqt_pkg::ST_OK, !out_result_valid && out_result_proc == '0, "failed result names a process")
  `SBQT_ASSERT_NEXT(a_result_loaded, res_valid && res_ready, out_valid, "result lost on transfer")

endmodule
